// File: rtl/core/fcph_pkg.sv
package fcph_pkg;

	localparam int JOB_DEPTH = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] OP_REQ_CTRL = 8'h00;
	localparam logic [7:0] OP_RESET = 8'h01;
	localparam logic [7:0] OP_TARGET_LEVEL = 8'h04;
	localparam logic [7:0] OP_START = 8'h07;
	localparam logic [7:0] OP_STOP = 8'h08;
	localparam logic [7:0] OP_SIMULATION = 8'h11;

	localparam logic [7:0] RC_SUCCESS = 8'h01;
	localparam logic [7:0] RC_UNSUPPORTED = 8'h02;
	localparam logic [7:0] RC_INVALID = 8'h03;

	localparam logic [7:0] MSG_RESPONSE = 8'h80;
	localparam logic [7:0] MSG_LEVEL_CHANGED = 8'h07;
	localparam logic [7:0] MSG_SIM_CHANGED = 8'h12;
	localparam logic [15:0] TS_MANUAL = 16'h0D00;
	localparam logic [15:0] TS_IDLE = 16'h0100;

	localparam logic [55:0] EVT_TARGET_LEVEL = 56'd1;
	localparam logic [55:0] EVT_SIMULATION = 56'd2;

	localparam logic [0:0] CFG_MIN_LEVEL = 1'b0;
	localparam logic [0:0] CFG_MAX_LEVEL = 1'b1;

	typedef enum logic [1:0] {
		CH_RESPONSE = 2'd0,
		CH_TRAINING = 2'd1,
		CH_MACHINE = 2'd2,
		CH_EVENT = 2'd3
	} channel_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [4:0] msg_length;
		logic [47:0] param_bytes;
		logic link_up;
	} in_item_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [2:0] out_length;
		logic [55:0] out_bytes;
		logic last;
		logic [7:0] target_level;
		logic signed [15:0] grade_now;
	} out_item_t;

	typedef struct packed {
		logic [1:0] channel;
		logic [2:0] out_length;
		logic [55:0] out_bytes;
	} res_t;

	// One job holds every result that a request causes, in order.
	typedef struct packed {
		logic [1:0] cnt;
		res_t [2:0] res;
		logic [7:0] target_level;
		logic signed [15:0] grade_now;
	} job_t;

endpackage

// File: rtl/core/fcph_front.sv
module fcph_front import fcph_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_item_t in_item,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic job_full,
	output logic job_push,
	output job_t job
);

	logic [7:0] min_level_q, max_level_q;
	logic [7:0] level_q;
	logic [15:0] wind_q, grade_q;
	logic [7:0] rolling_q, drag_q;

	logic [7:0] op, byte1, rc, level_new;
	logic [4:0] len;
	logic link, level_ok, sim_ok, changed;
	logic [47:0] kept;
	logic [15:0] w, g;
	logic [7:0] r, d;
	res_t resp, status_r, event_r;

	assign job_push = push && !job_full;
	assign op = in_item.opcode;
	assign len = in_item.msg_length;
	assign link = in_item.link_up;
	assign byte1 = in_item.param_bytes[7:0];

	assign level_ok = (len == 5'd2) && (byte1 >= min_level_q) && (byte1 <= max_level_q);
	assign sim_ok = (len == 5'd3) || (len == 5'd5) || (len == 5'd6) || (len == 5'd7);
	assign level_new = (op == OP_TARGET_LEVEL && level_ok) ? byte1 : level_q;

	// Parameters past the end of the message read as zero.
	always_comb begin
		case (len)
			5'd3: kept = {32'd0, in_item.param_bytes[15:0]};
			5'd5: kept = {16'd0, in_item.param_bytes[31:0]};
			5'd6: kept = {8'd0, in_item.param_bytes[39:0]};
			default: kept = in_item.param_bytes;
		endcase
	end

	assign w = kept[15:0];
	assign g = kept[31:16];
	assign r = kept[39:32];
	assign d = kept[47:40];
	assign changed = sim_ok && ((w != wind_q) || (g != grade_q) || (r != rolling_q) ||
		(d != drag_q));

	always_comb begin
		case (op)
			OP_REQ_CTRL, OP_RESET, OP_START: rc = (len == 5'd1) ? RC_SUCCESS : RC_INVALID;
			OP_STOP: rc = (len == 5'd2) ? RC_SUCCESS : RC_INVALID;
			OP_TARGET_LEVEL: rc = level_ok ? RC_SUCCESS : RC_INVALID;
			OP_SIMULATION: rc = sim_ok ? RC_SUCCESS : RC_INVALID;
			default: rc = RC_UNSUPPORTED;
		endcase
	end

	always_comb begin
		resp = '{channel: CH_RESPONSE, out_length: 3'd3,
			out_bytes: {32'd0, rc, op, MSG_RESPONSE}};
		status_r = '{channel: CH_TRAINING, out_length: 3'd2, out_bytes: {40'd0, TS_MANUAL}};
		event_r = '{channel: CH_EVENT, out_length: 3'd1, out_bytes: EVT_TARGET_LEVEL};
		job.cnt = 2'd1;
		case (op)
			OP_RESET, OP_START: begin
				job.cnt = link ? 2'd2 : 2'd1;
			end
			OP_STOP: begin
				status_r.out_bytes = {40'd0, TS_IDLE};
				job.cnt = link ? 2'd2 : 2'd1;
			end
			OP_TARGET_LEVEL: begin
				status_r = '{channel: CH_MACHINE, out_length: 3'd2,
					out_bytes: {40'd0, level_new, MSG_LEVEL_CHANGED}};
				job.cnt = link ? 2'd3 : 2'd2;
			end
			OP_SIMULATION: begin
				status_r = '{channel: CH_MACHINE, out_length: len[2:0],
					out_bytes: {kept, MSG_SIM_CHANGED}};
				event_r.out_bytes = EVT_SIMULATION;
				if (changed) begin
					job.cnt = link ? 2'd3 : 2'd2;
				end
			end
			default: begin
				job.cnt = 2'd1;
			end
		endcase
		job.res[0] = resp;
		job.res[1] = link ? status_r : event_r;
		job.res[2] = event_r;
		job.target_level = level_new;
		job.grade_now = (op == OP_SIMULATION && sim_ok) ? g : grade_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= 8'd0;
			max_level_q <= 8'hFF;
			level_q <= 8'd0;
			wind_q <= 16'd0;
			grade_q <= 16'd0;
			rolling_q <= 8'd0;
			drag_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_LEVEL: min_level_q <= cfg_wdata;
					CFG_MAX_LEVEL: max_level_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (job_push) begin
				level_q <= level_new;
				if (op == OP_SIMULATION && sim_ok) begin
					wind_q <= w;
					grade_q <= g;
					rolling_q <= r;
					drag_q <= d;
				end
			end
		end
	end

endmodule

// File: rtl/core/fcph_job_fifo.sv
module fcph_job_fifo import fcph_pkg::*; #(
	parameter int Depth = JOB_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic valid,
	output job_t rd_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t mem [Depth];
	job_t head_q;
	logic head_valid_q;
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic refill;

	// The head register holds the oldest job. It is refilled from the array
	// whenever it is empty or its job is being taken.
	assign full = (count_q == CntW'(Depth));
	assign refill = (!head_valid_q || rd_en) && (count_q != '0);
	assign valid = head_valid_q;
	assign rd_job = head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_job;
		end
		if (refill) begin
			head_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (refill) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !refill) begin
				count_q <= count_q + 1'b1;
			end else if (refill && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
			if (refill) begin
				head_valid_q <= 1'b1;
			end else if (rd_en) begin
				head_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/fcph_back.sv
module fcph_back import fcph_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic empty,
	input  logic pop,
	output out_item_t out_item
);

	logic [1:0] idx_q;
	logic out_valid_q;
	out_item_t out_q;
	logic load, is_last;
	res_t cur;

	assign load = job_valid && (!out_valid_q || pop);
	assign cur = job.res[idx_q];
	assign is_last = (idx_q == job.cnt - 2'd1);
	assign job_pop = load && is_last;
	assign empty = !out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= '{channel: cur.channel, out_length: cur.out_length,
				out_bytes: cur.out_bytes, last: is_last,
				target_level: job.target_level, grade_now: job.grade_now};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/fitness_control_point_handler_core.sv
// Channel  Direction  Handshake               Payload
// request  in         push / full             in_item (in_item_t)
// result   out        pop / empty             out_item (out_item_t)
// config   in         cfg_we, no wait         cfg_index, cfg_wdata
//
// The front part checks a request and updates the stored level and simulation
// values in the cycle it is accepted, and queues one job holding all of its
// results. The back part issues the one to three results of a job in order;
// the result register limits the rate to one result per cycle while pop keeps
// it free. Requests are taken back to back while the job queue has room.
// Reset clears the configuration to its defaults, the stored values to zero
// and both queues to empty. A stalled result side fills the job queue and then
// raises full.
module fitness_control_point_handler_core import fcph_pkg::*; #(
	parameter int JobDepth = JOB_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_item_t in_item,
	output logic empty,
	input  logic pop,
	output out_item_t out_item,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic job_push, job_pop, job_valid;
	job_t job_in, job_out;

	// Classify the request and update the stored state.
	fcph_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.in_item(in_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.job_full(full),
		.job_push(job_push),
		.job(job_in)
	);

	// The job queue decouples acceptance from result delivery.
	fcph_job_fifo #(
		.Depth(JobDepth)
	) u_job_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_job(job_in),
		.full(full),
		.rd_en(job_pop),
		.valid(job_valid),
		.rd_job(job_out)
	);

	// Sequence the results of each job into the output register.
	fcph_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job_out),
		.job_pop(job_pop),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);

endmodule

// File: test/cp_response_board_pkg.sv
`timescale 1ns / 1ps

package cp_response_board_pkg;
	import fcph_pkg::*;

	// Keeps its own copy of the level bounds and the stored values, works out
	// every result that a request causes and checks them in order.
	class cp_response_board;
		logic [7:0] level_floor = 8'd0;
		logic [7:0] level_ceiling = 8'd255;
		logic [7:0] held_level = '0;
		logic [15:0] held_wind = '0;
		logic [15:0] held_grade = '0;
		logic [7:0] held_rolling = '0;
		logic [7:0] held_drag = '0;
		out_item_t expected_results[$];
		int failures = 0;

		function void set_bound(logic [CFG_IDX_W-1:0] index, logic [7:0] value);
			if (index == CFG_MIN_LEVEL) begin
				level_floor = value;
			end else if (index == CFG_MAX_LEVEL) begin
				level_ceiling = value;
			end
		endfunction

		function void note_request(in_item_t rq);
			out_item_t batch[$];
			out_item_t res;
			logic [7:0] rc;
			logic [47:0] kept;
			logic [47:0] keep_mask;
			logic [7:0] level_byte;
			logic changed;
			logic [15:0] new_wind;
			logic [15:0] new_grade;
			logic [7:0] new_rolling;
			logic [7:0] new_drag;

			rc = RC_INVALID;
			changed = 1'b0;
			kept = '0;
			level_byte = rq.param_bytes[7:0];
			case (rq.opcode)
				OP_REQ_CTRL, OP_RESET, OP_START: begin
					if (rq.msg_length == 5'd1) rc = RC_SUCCESS;
				end
				OP_STOP: begin
					if (rq.msg_length == 5'd2) rc = RC_SUCCESS;
				end
				OP_TARGET_LEVEL: begin
					if (rq.msg_length == 5'd2 && level_byte >= level_floor &&
							level_byte <= level_ceiling) begin
						held_level = level_byte;
						rc = RC_SUCCESS;
					end
				end
				OP_SIMULATION: begin
					if (rq.msg_length inside {5'd3, 5'd5, 5'd6, 5'd7}) begin
						// Parameters past the message length read as zero.
						if (rq.msg_length == 5'd7) begin
							keep_mask = '1;
						end else begin
							keep_mask = (48'h1 << (8 * (rq.msg_length - 5'd1))) - 48'h1;
						end
						kept = rq.param_bytes & keep_mask;
						new_wind = kept[15:0];
						new_grade = kept[31:16];
						new_rolling = kept[39:32];
						new_drag = kept[47:40];
						rc = RC_SUCCESS;
						changed = (new_wind != held_wind) || (new_grade != held_grade) ||
							(new_rolling != held_rolling) || (new_drag != held_drag);
						held_wind = new_wind;
						held_grade = new_grade;
						held_rolling = new_rolling;
						held_drag = new_drag;
					end
				end
				default: rc = RC_UNSUPPORTED;
			endcase

			res = '0;
			res.channel = CH_RESPONSE;
			res.out_length = 3'd3;
			res.out_bytes = {32'h0, rc, rq.opcode, MSG_RESPONSE};
			batch.push_back(res);

			case (rq.opcode)
				OP_RESET, OP_START, OP_STOP: begin
					if (rq.link_up) begin
						res.channel = CH_TRAINING;
						res.out_length = 3'd2;
						res.out_bytes = {40'h0, (rq.opcode == OP_STOP) ? TS_IDLE : TS_MANUAL};
						batch.push_back(res);
					end
				end
				OP_TARGET_LEVEL: begin
					if (rq.link_up) begin
						res.channel = CH_MACHINE;
						res.out_length = 3'd2;
						res.out_bytes = {40'h0, held_level, MSG_LEVEL_CHANGED};
						batch.push_back(res);
					end
					res.channel = CH_EVENT;
					res.out_length = 3'd1;
					res.out_bytes = EVT_TARGET_LEVEL;
					batch.push_back(res);
				end
				OP_SIMULATION: begin
					if (changed) begin
						if (rq.link_up) begin
							res.channel = CH_MACHINE;
							res.out_length = rq.msg_length[2:0];
							res.out_bytes = {kept, MSG_SIM_CHANGED};
							batch.push_back(res);
						end
						res.channel = CH_EVENT;
						res.out_length = 3'd1;
						res.out_bytes = EVT_SIMULATION;
						batch.push_back(res);
					end
				end
				default: ;
			endcase

			foreach (batch[i]) begin
				batch[i].last = (i == batch.size() - 1);
				batch[i].target_level = held_level;
				batch[i].grade_now = held_grade;
				expected_results.push_back(batch[i]);
			end
		endfunction

		function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
				failures++;
			end
		endfunction

		function void check_result(out_item_t act);
			out_item_t exp_r;

			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, act);
				failures++;
				return;
			end
			exp_r = expected_results.pop_front();
			compare_field("channel", 64'(exp_r.channel), 64'(act.channel));
			compare_field("out_length", 64'(exp_r.out_length), 64'(act.out_length));
			compare_field("out_bytes", 64'(exp_r.out_bytes), 64'(act.out_bytes));
			compare_field("last", 64'(exp_r.last), 64'(act.last));
			compare_field("target_level", 64'(exp_r.target_level), 64'(act.target_level));
			compare_field("grade_now", 64'(exp_r.grade_now), 64'(act.grade_now));
		endfunction
	endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the fitness machine control point handler.
// Requests go in through a push/full queue port and results come out through
// an empty/pop port. A scoreboard object predicts every result of each
// accepted request and checks the results in order, field by field.
module tb_top;
	import fcph_pkg::*;
	import cp_response_board_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 42;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cp_response_board board = new();

	// Idle rates in percent. The receiver rate and the hold request are set
	// with nonblocking writes so they do not race with the receiver process.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_req = 1'b0;

	// The receiver owns these; the hold is counted here, in its own process.
	int stall_left = 0;
	logic hold_taken = 1'b0;
	int cycle_count = 0;

	// The generator keeps the bounds and the last simulation parameters it
	// sent, so that it can aim at the range edges and repeat unchanged values.
	logic [7:0] cur_min = 8'd0;
	logic [7:0] cur_max = 8'd255;
	logic [47:0] prev_sim = '0;
	logic [4:0] prev_sim_len = 5'd7;

	fitness_control_point_handler_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// A watchdog so that a hung block cannot stall the run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fitness_control_point_handler_core verification failed");
			$finish;
		end
	end

	// Receiver. Values read right after the edge are those from before it, so
	// pop and empty here describe exactly the handshake at this edge. A long
	// hold, when asked for, keeps pop low while the sender keeps pushing.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			board.check_result(out_item);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			stall_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic in_item_t make_request(logic [7:0] op, logic [4:0] len,
			logic [47:0] params, logic link);
		in_item_t rq;

		rq.opcode = op;
		rq.msg_length = len;
		rq.param_bytes = params;
		rq.link_up = link;
		return rq;
	endfunction

	// Mostly well-formed requests with random content, with some noise and
	// some wrong lengths mixed in.
	function automatic in_item_t random_request();
		in_item_t rq;
		int pick;

		rq.param_bytes[31:0] = $urandom();
		rq.param_bytes[47:32] = 16'($urandom());
		rq.link_up = ($urandom_range(3) != 0);
		pick = $urandom_range(99);
		if (pick < 12) begin
			rq.opcode = 8'($urandom());
			rq.msg_length = 5'($urandom());
			return rq;
		end
		case ($urandom_range(5))
			0: begin
				rq.opcode = OP_REQ_CTRL;
				rq.msg_length = 5'd1;
			end
			1: begin
				rq.opcode = OP_RESET;
				rq.msg_length = 5'd1;
			end
			2: begin
				rq.opcode = OP_START;
				rq.msg_length = 5'd1;
			end
			3: begin
				rq.opcode = OP_STOP;
				rq.msg_length = 5'd2;
			end
			4: begin
				rq.opcode = OP_TARGET_LEVEL;
				rq.msg_length = 5'd2;
				case ($urandom_range(4))
					0: rq.param_bytes[7:0] = cur_min;
					1: rq.param_bytes[7:0] = cur_max;
					2: rq.param_bytes[7:0] = cur_min - 8'd1;
					3: rq.param_bytes[7:0] = cur_max + 8'd1;
					default: ;
				endcase
			end
			default: begin
				rq.opcode = OP_SIMULATION;
				if ($urandom_range(2) == 0) begin
					// Repeat the last generated values; no change is reported if they are still held.
					rq.param_bytes = prev_sim;
					rq.msg_length = prev_sim_len;
				end else begin
					case ($urandom_range(3))
						0: rq.msg_length = 5'd3;
						1: rq.msg_length = 5'd5;
						2: rq.msg_length = 5'd6;
						default: rq.msg_length = 5'd7;
					endcase
					prev_sim = rq.param_bytes;
					prev_sim_len = rq.msg_length;
				end
			end
		endcase
		// A few requests of a known kind carry a wrong length.
		if (pick >= 88) begin
			rq.msg_length = 5'($urandom_range(31));
		end
		return rq;
	endfunction

	// Offers one request and returns at the edge that accepts it. Push stays
	// high on return, so back-to-back requests never drop it in between.
	task automatic send_request(in_item_t rq);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_item <= rq;
		do begin
			@(posedge clk);
		end while (full);
		board.note_request(rq);
	endtask

	// Drops push and waits until every expected result has been taken, then a
	// settling wait for the block to go quiet.
	task automatic settle();
		push <= 1'b0;
		do begin
			@(posedge clk);
		end while (board.expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one level bound; only called while the block is idle.
	task automatic write_bound(logic [CFG_IDX_W-1:0] index, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_bound(index, value);
		if (index == CFG_MIN_LEVEL) begin
			cur_min = value;
		end else begin
			cur_max = value;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		repeat (ITEMS_PER_PHASE) send_request(random_request());
		settle();
	endtask

	initial begin
		in_item_t directed[$];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The widest range first, written explicitly.
		write_bound(CFG_MIN_LEVEL, 8'd0);
		write_bound(CFG_MAX_LEVEL, 8'd255);

		// Directed part: every opcode with good and bad lengths, the link both
		// up and down, bytes beyond the length that must be ignored, a zero
		// and a maximal length field, level range edges, unchanged and changed
		// simulation values, the most negative grade and unsupported opcodes.
		directed.push_back(make_request(OP_REQ_CTRL, 5'd1, '0, 1'b1));
		directed.push_back(make_request(OP_REQ_CTRL, 5'd2, '1, 1'b1));
		directed.push_back(make_request(OP_RESET, 5'd1, '0, 1'b1));
		directed.push_back(make_request(OP_RESET, 5'd3, '0, 1'b0));
		directed.push_back(make_request(OP_START, 5'd1, '0, 1'b0));
		directed.push_back(make_request(OP_START, 5'd0, '0, 1'b1));
		directed.push_back(make_request(OP_STOP, 5'd2, 48'h01, 1'b1));
		directed.push_back(make_request(OP_STOP, 5'd1, '0, 1'b1));
		directed.push_back(make_request(OP_STOP, 5'd2, '0, 1'b0));
		directed.push_back(make_request(OP_TARGET_LEVEL, 5'd2, 48'hFFFF_FFFF_FF00, 1'b1));
		directed.push_back(make_request(OP_TARGET_LEVEL, 5'd2, 48'h0000_0000_00FF, 1'b1));
		directed.push_back(make_request(OP_TARGET_LEVEL, 5'd3, 48'h40, 1'b1));
		directed.push_back(make_request(OP_TARGET_LEVEL, 5'd2, 48'h80, 1'b0));
		directed.push_back(make_request(OP_SIMULATION, 5'd3, '1, 1'b1));
		directed.push_back(make_request(OP_SIMULATION, 5'd3, '1, 1'b1));
		directed.push_back(make_request(OP_SIMULATION, 5'd7, '1, 1'b1));
		directed.push_back(make_request(OP_SIMULATION, 5'd5, 48'h1234_8000_0010, 1'b0));
		directed.push_back(make_request(OP_SIMULATION, 5'd6, 48'h5A33_7FFF_0000, 1'b1));
		directed.push_back(make_request(OP_SIMULATION, 5'd4, 48'h0102_0304_0506, 1'b1));
		directed.push_back(make_request(OP_SIMULATION, 5'd7, '0, 1'b1));
		directed.push_back(make_request(OP_SIMULATION, 5'd31, 48'h1, 1'b1));
		directed.push_back(make_request(8'hFF, 5'd1, '0, 1'b1));
		directed.push_back(make_request(8'h12, 5'd20, '1, 1'b0));
		directed.push_back(make_request(8'h80, 5'd0, '0, 1'b1));
		foreach (directed[i]) send_request(directed[i]);
		settle();

		// An inverted range must reject every level.
		write_bound(CFG_MIN_LEVEL, 8'd200);
		write_bound(CFG_MAX_LEVEL, 8'd100);
		send_request(make_request(OP_TARGET_LEVEL, 5'd2, 48'd150, 1'b1));
		send_request(make_request(OP_TARGET_LEVEL, 5'd2, 48'd200, 1'b1));
		send_request(make_request(OP_TARGET_LEVEL, 5'd2, 48'd100, 1'b0));
		settle();

		// Random part, one bound setting per phase.
		write_bound(CFG_MIN_LEVEL, 8'($urandom_range(100)));
		write_bound(CFG_MAX_LEVEL, 8'($urandom_range(255, 150)));
		random_phase(31, 84);

		write_bound(CFG_MIN_LEVEL, 8'd255);
		write_bound(CFG_MAX_LEVEL, 8'd255);
		random_phase(84, 31);

		// No idling here, and the receiver takes one long hold, so the job
		// queue fills and full must hold off the sender.
		write_bound(CFG_MIN_LEVEL, 8'($urandom_range(255)));
		write_bound(CFG_MAX_LEVEL, 8'($urandom_range(255)));
		hold_req <= 1'b1;
		random_phase(0, 0);

		if (board.failures == 0 && board.expected_results.size() == 0) begin
			$display("fitness_control_point_handler_core verification clean");
		end else begin
			$display("fitness_control_point_handler_core verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/fcph_pkg.sv
rtl/core/fcph_front.sv
rtl/core/fcph_job_fifo.sv
rtl/core/fcph_back.sv
rtl/core/fitness_control_point_handler_core.sv
test/cp_response_board_pkg.sv
test/tb_top.sv
